// ===== hw/rtl/chte_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chte_pkg
// Shared opcodes, sequencer states and a key-size constant for the hash engine.
// ----------------------------------------------------------------------------
package chte_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_LENGTH = 2'd3
    } opcode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HASH,
        ST_MOD,
        ST_HEAD_RD,
        ST_HEAD_WAIT,
        ST_WALK_RD,
        ST_WALK_WAIT,
        ST_CHECK,
        ST_UNLINK,
        ST_FREE,
        ST_INSERT,
        ST_INSERT_HEAD,
        ST_RESULT
    } state_t;

    localparam int KEY_BYTES = 16;

endpackage

// ===== hw/rtl/chte_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chte_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module chte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/chained_hash_table_engine_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_table_engine_top
// Hash table engine: one sequencer drives a shared byte adder for hashing,
// a subtract-compare for the bucket modulo, and chain walks through RAMs.
// ----------------------------------------------------------------------------
// Sequence: ST_HASH sums the key bytes, ST_MOD reduces the sum by repeated
// subtraction, the bucket head is read, each chain entry is read and checked in
// turn, a delete or insert then updates the RAMs, and the result is presented.
// Throughput: one request at a time; ready is low until the result is taken.
// Reset: a clearing pass writes null heads and the initial free-list links
// before the first request is accepted.
module chained_hash_table_engine_top #(
    parameter int BUCKET_COUNT = 97,
    parameter int POOL_ENTRIES = 64,
    parameter int KEY_CHARS    = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [63:0] key_chars_low,
    input  logic [15:0] key_chars_high,
    input  logic [6:0]  bucket_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        found,
    output logic [5:0]  entry_index,
    output logic [6:0]  chain_length,
    output logic        status
);

    localparam int BW   = $clog2(BUCKET_COUNT);
    localparam int EW   = $clog2(POOL_ENTRIES);
    localparam int LW   = EW + 1;
    localparam int KW   = 8 * KEY_CHARS;
    localparam int SW   = $clog2(255 * KEY_CHARS + 1) + 1;
    localparam int CW   = (BW > EW ? BW : EW) + 1;
    localparam int CLR  = (BUCKET_COUNT > POOL_ENTRIES) ? BUCKET_COUNT : POOL_ENTRIES;
    localparam int KCW  = $clog2(KEY_CHARS + 1);
    localparam int NCW  = $clog2(POOL_ENTRIES + 1);
    localparam logic [LW-1:0] NULL_LINK = {1'b1, {EW{1'b0}}};

    // Registers
    chte_pkg::state_t state_reg, state_next;
    logic             clearing_reg, clearing_next;
    logic [CW-1:0]    clr_cnt_reg, clr_cnt_next;
    chte_pkg::opcode_t op_reg, op_next;
    logic [KW-1:0]    key_reg, key_next;
    logic [6:0]       bidx_reg, bidx_next;
    logic [KCW-1:0]   kpos_reg, kpos_next;
    logic             ended_reg, ended_next;
    logic [SW-1:0]    sum_reg, sum_next;
    logic [BW-1:0]    hash_reg, hash_next;
    logic [LW-1:0]    cur_reg, cur_next;
    logic [LW-1:0]    prev_reg, prev_next;
    logic [LW-1:0]    free_reg, free_next;
    logic [NCW-1:0]   steps_reg, steps_next;
    logic             found_reg, found_next;
    logic [5:0]       idx_reg, idx_next;
    logic [6:0]       len_reg, len_next;
    logic             status_reg, status_next;

    // RAM ports
    logic            hd_we;
    logic [BW-1:0]   hd_waddr, hd_raddr;
    logic [LW-1:0]   hd_wdata, hd_rdata;
    logic            lk_we;
    logic [EW-1:0]   lk_waddr, lk_raddr;
    logic [LW-1:0]   lk_wdata, lk_rdata;
    logic            ky_we;
    logic [EW-1:0]   ky_waddr, ky_raddr;
    logic [KW-1:0]   ky_wdata, ky_rdata;

    chte_ram #(.WIDTH(LW), .DEPTH(BUCKET_COUNT)) u_heads (
        .clk(clk), .we(hd_we), .waddr(hd_waddr), .wdata(hd_wdata),
        .raddr(hd_raddr), .rdata(hd_rdata)
    );
    chte_ram #(.WIDTH(LW), .DEPTH(POOL_ENTRIES)) u_links (
        .clk(clk), .we(lk_we), .waddr(lk_waddr), .wdata(lk_wdata),
        .raddr(lk_raddr), .rdata(lk_rdata)
    );
    chte_ram #(.WIDTH(KW), .DEPTH(POOL_ENTRIES)) u_keys (
        .clk(clk), .we(ky_we), .waddr(ky_waddr), .wdata(ky_wdata),
        .raddr(ky_raddr), .rdata(ky_rdata)
    );

    logic [79:0]  raw_key;
    logic [7:0]   cur_byte;
    logic [KW-1:0] byte_mask;

    assign raw_key = {key_chars_high, key_chars_low};

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= chte_pkg::ST_IDLE;
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            free_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clearing_reg <= clearing_next;
            clr_cnt_reg  <= clr_cnt_next;
            free_reg     <= free_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        bidx_reg   <= bidx_next;
        kpos_reg   <= kpos_next;
        ended_reg  <= ended_next;
        sum_reg    <= sum_next;
        hash_reg   <= hash_next;
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        steps_reg  <= steps_next;
        found_reg  <= found_next;
        idx_reg    <= idx_next;
        len_reg    <= len_next;
        status_reg <= status_next;
    end

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        clearing_next = clearing_reg;
        clr_cnt_next  = clr_cnt_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        bidx_next     = bidx_reg;
        kpos_next     = kpos_reg;
        ended_next    = ended_reg;
        sum_next      = sum_reg;
        hash_next     = hash_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        free_next     = free_reg;
        steps_next    = steps_reg;
        found_next    = found_reg;
        idx_next      = idx_reg;
        len_next      = len_reg;
        status_next   = status_reg;
        hd_we = 1'b0; hd_waddr = hash_reg; hd_wdata = NULL_LINK; hd_raddr = hash_reg;
        lk_we = 1'b0; lk_waddr = cur_reg[EW-1:0]; lk_wdata = NULL_LINK;
        lk_raddr = cur_reg[EW-1:0];
        ky_we = 1'b0; ky_waddr = free_reg[EW-1:0]; ky_wdata = key_reg;
        ky_raddr = cur_reg[EW-1:0];
        in_ready  = 1'b0;
        out_valid = 1'b0;
        cur_byte  = key_reg[8*kpos_reg[$clog2(KEY_CHARS > 1 ? KEY_CHARS : 2)-1:0] +: 8];
        byte_mask = '0;
        unique case (state_reg)
            chte_pkg::ST_IDLE:
            begin
                if (clearing_reg)
                begin
                    // Sweep heads to null and links to the initial free chain
                    if (clr_cnt_reg < CW'(BUCKET_COUNT))
                    begin
                        hd_we    = 1'b1;
                        hd_waddr = clr_cnt_reg[BW-1:0];
                    end
                    if (clr_cnt_reg < CW'(POOL_ENTRIES))
                    begin
                        lk_we    = 1'b1;
                        lk_waddr = clr_cnt_reg[EW-1:0];
                        lk_wdata = (clr_cnt_reg == CW'(POOL_ENTRIES - 1)) ? NULL_LINK
                                   : LW'(clr_cnt_reg + CW'(1));
                    end
                    clr_cnt_next = clr_cnt_reg + CW'(1);
                    if (clr_cnt_reg == CW'(CLR - 1))
                    begin
                        clearing_next = 1'b0;
                    end
                end
                else
                begin
                    in_ready = 1'b1;
                    if (in_valid)
                    begin
                        op_next     = chte_pkg::opcode_t'(opcode);
                        bidx_next   = bucket_index;
                        key_next    = raw_key[KW-1:0];
                        kpos_next   = '0;
                        ended_next  = 1'b0;
                        sum_next    = '0;
                        steps_next  = '0;
                        prev_next   = NULL_LINK;
                        found_next  = 1'b0;
                        idx_next    = '0;
                        len_next    = '0;
                        status_next = 1'b0;
                        if (chte_pkg::opcode_t'(opcode) == chte_pkg::OP_LENGTH)
                        begin
                            if (bucket_index < 7'(BUCKET_COUNT))
                            begin
                                hash_next  = BW'(bucket_index);
                                state_next = chte_pkg::ST_HEAD_RD;
                            end
                            else
                            begin
                                state_next = chte_pkg::ST_RESULT;
                            end
                        end
                        else
                        begin
                            state_next = chte_pkg::ST_HASH;
                        end
                    end
                end
            end
            chte_pkg::ST_HASH:
            begin
                // Add one byte; zero the key from its terminator on
                if (ended_reg || cur_byte == 8'd0)
                begin
                    ended_next = 1'b1;
                    byte_mask[8*kpos_reg[$clog2(KEY_CHARS > 1 ? KEY_CHARS : 2)-1:0] +: 8]
                        = 8'hFF;
                    key_next = key_reg & ~byte_mask;
                end
                else
                begin
                    sum_next = sum_reg + SW'(cur_byte);
                end
                kpos_next = kpos_reg + KCW'(1);
                if (kpos_reg == KCW'(KEY_CHARS - 1))
                begin
                    state_next = chte_pkg::ST_MOD;
                end
            end
            chte_pkg::ST_MOD:
            begin
                // Repeated subtract for the bucket modulo
                if (sum_reg >= SW'(BUCKET_COUNT))
                begin
                    sum_next = sum_reg - SW'(BUCKET_COUNT);
                end
                else
                begin
                    hash_next  = sum_reg[BW-1:0];
                    state_next = chte_pkg::ST_HEAD_RD;
                end
            end
            chte_pkg::ST_HEAD_RD:
            begin
                hd_raddr   = hash_reg;
                state_next = chte_pkg::ST_HEAD_WAIT;
            end
            chte_pkg::ST_HEAD_WAIT:
            begin
                cur_next   = hd_rdata;
                state_next = chte_pkg::ST_CHECK;
            end
            chte_pkg::ST_CHECK:
            begin
                // Stop at null or after a full pool's worth of steps
                if (cur_reg[EW] || steps_reg == NCW'(POOL_ENTRIES))
                begin
                    if (op_reg == chte_pkg::OP_LENGTH)
                    begin
                        len_next   = 7'(steps_reg);
                        state_next = chte_pkg::ST_RESULT;
                    end
                    else if (op_reg == chte_pkg::OP_INSERT)
                    begin
                        state_next = chte_pkg::ST_INSERT;
                    end
                    else
                    begin
                        state_next = chte_pkg::ST_RESULT;
                    end
                end
                else
                begin
                    lk_raddr   = cur_reg[EW-1:0];
                    ky_raddr   = cur_reg[EW-1:0];
                    state_next = chte_pkg::ST_WALK_WAIT;
                end
            end
            chte_pkg::ST_WALK_WAIT:
            begin
                if (op_reg != chte_pkg::OP_LENGTH && ky_rdata == key_reg)
                begin
                    found_next = 1'b1;
                    idx_next   = 6'(cur_reg[EW-1:0]);
                    if (op_reg == chte_pkg::OP_DELETE)
                    begin
                        state_next = chte_pkg::ST_UNLINK;
                    end
                    else
                    begin
                        state_next = chte_pkg::ST_RESULT;
                    end
                end
                else
                begin
                    prev_next  = cur_reg;
                    cur_next   = lk_rdata;
                    steps_next = steps_reg + NCW'(1);
                    state_next = chte_pkg::ST_CHECK;
                end
            end
            chte_pkg::ST_WALK_RD:
            begin
                state_next = chte_pkg::ST_CHECK;
            end
            chte_pkg::ST_UNLINK:
            begin
                // Bypass the found entry; its link is still on the read port
                if (prev_reg[EW])
                begin
                    hd_we    = 1'b1;
                    hd_waddr = hash_reg;
                    hd_wdata = lk_rdata;
                end
                else
                begin
                    lk_we    = 1'b1;
                    lk_waddr = prev_reg[EW-1:0];
                    lk_wdata = lk_rdata;
                end
                state_next = chte_pkg::ST_FREE;
            end
            chte_pkg::ST_FREE:
            begin
                // Push the entry onto the free list
                lk_we      = 1'b1;
                lk_waddr   = cur_reg[EW-1:0];
                lk_wdata   = free_reg;
                free_next  = cur_reg;
                state_next = chte_pkg::ST_RESULT;
            end
            chte_pkg::ST_INSERT:
            begin
                if (free_reg[EW])
                begin
                    status_next = 1'b1;
                    state_next  = chte_pkg::ST_RESULT;
                end
                else
                begin
                    // Fetch the free entry's link and head of the bucket
                    lk_raddr   = free_reg[EW-1:0];
                    hd_raddr   = hash_reg;
                    state_next = chte_pkg::ST_INSERT_HEAD;
                end
            end
            chte_pkg::ST_INSERT_HEAD:
            begin
                ky_we     = 1'b1;
                ky_waddr  = free_reg[EW-1:0];
                lk_we     = 1'b1;
                lk_waddr  = free_reg[EW-1:0];
                lk_wdata  = hd_rdata;
                hd_we     = 1'b1;
                hd_waddr  = hash_reg;
                hd_wdata  = free_reg;
                idx_next  = 6'(free_reg[EW-1:0]);
                free_next = lk_rdata;
                state_next = chte_pkg::ST_RESULT;
            end
            chte_pkg::ST_RESULT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = chte_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = chte_pkg::ST_IDLE;
            end
        endcase
    end

    assign found        = found_reg;
    assign entry_index  = idx_reg;
    assign chain_length = len_reg;
    assign status       = status_reg;

endmodule
